/* rtl/core/topic_subscription_table_core_defines.svh */
// Assertion macros shared by the topic subscription table RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef TOPIC_SUBSCRIPTION_TABLE_CORE_DEFINES_SVH
`define TOPIC_SUBSCRIPTION_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define TST_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define TST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TST_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define TST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/tst_pkg.sv */
// Types and fixed widths of the topic subscription table.
// Depends on nothing; used by topic_subscription_table_core.
package tst_pkg;

  localparam int unsigned TOPIC_W = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned REFS_W  = 32;
  localparam int unsigned SLOT_W  = 5;

  typedef enum logic [1:0] {
    OP_SUBSCRIBE   = 2'd0,
    OP_UNSUBSCRIBE = 2'd1,
    OP_RECEIVE     = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_COUNTED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

endpackage

/* rtl/core/topic_subscription_table_core.sv */
// Topic subscription table: slot memory, lookup sequencer and result register.
// Depends on tst_pkg and topic_subscription_table_core_defines.svh.
//
// A fully associative table of ENTRIES subscription slots. Each item is a
// subscribe, unsubscribe or receive request for one topic, and each item
// yields exactly one result item with a status, the slot touched and, for a
// receive, the new saturating reference count. The slot state (valid mark,
// topic and count) lives in a synchronous memory with one read port and one
// write port and a registered read; peer address and port live in a
// second, write-only memory.
// After reset the block runs a clearing pass over every slot of the slot
// memory and holds in_ready low until it is done. Each item is then accepted,
// every slot is streamed through the read port and compared, and the slot is
// written back while the result register is loaded. Unless the write-back
// stalls, most of each item's time goes to the lookup scan over the memory
// read port. The result register holds a finished result until it is taken
// while the next item is already being scanned; only the write-back waits for
// the result register to free. Topics match on the low TOPIC_BITS of topic_id,
// the lowest matching slot wins, and inserts fill the lowest free slot.
module topic_subscription_table_core #(
  parameter int unsigned ENTRIES    = 32,
  parameter int unsigned TOPIC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     opcode,
  input  logic [tst_pkg::TOPIC_W-1:0]    topic_id,
  input  logic [tst_pkg::ADDR_W-1:0]     peer_address,
  input  logic [tst_pkg::PORT_W-1:0]     peer_port,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tst_pkg::status_t               status,
  output logic [tst_pkg::SLOT_W-1:0]     slot_index,
  output logic [tst_pkg::REFS_W-1:0]     ref_count
);

  import tst_pkg::*;

`include "topic_subscription_table_core_defines.svh"

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned ENT_W  = 1 + TOPIC_BITS + REFS_W;
  localparam int unsigned PEER_W = ADDR_W + PORT_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t state;

  // Slot memory: {valid, topic, refs}. Peer memory: {address, port}.
  logic [ENT_W-1:0]  tbl_mem  [ENTRIES];
  logic [PEER_W-1:0] peer_mem [ENTRIES];

  logic [ENT_W-1:0]  rd_data;
  logic [IDX_W-1:0]  rd_slot;
  logic              rd_pending;
  logic [CNT_W-1:0]  cnt;

  // The item under work.
  opcode_t           op;
  logic [TOPIC_BITS-1:0] key;
  logic [ADDR_W-1:0] addr;
  logic [PORT_W-1:0] port;

  // Scan results.
  logic              found;
  logic [IDX_W-1:0]  hit_slot;
  logic [REFS_W-1:0] hit_refs;
  logic              free_found;
  logic [IDX_W-1:0]  free_slot;

  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  logic [ENT_W-1:0]  tbl_wdata;
  logic              peer_we;
  logic [IDX_W-1:0]  peer_waddr;
  logic [IDX_W-1:0]  raddr;

  status_t           res_status;
  logic [IDX_W-1:0]  res_slot;
  logic              res_has_slot;
  logic [REFS_W-1:0] res_count;
  logic [REFS_W-1:0] refs_inc;
  logic              out_free;

  logic              rd_valid;
  logic [TOPIC_BITS-1:0] rd_topic;
  logic [REFS_W-1:0] rd_refs;

  assign rd_valid = rd_data[ENT_W-1];
  assign rd_topic = rd_data[REFS_W +: TOPIC_BITS];
  assign rd_refs  = rd_data[REFS_W-1:0];

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign raddr    = cnt[IDX_W-1:0];
  assign refs_inc = (hit_refs == '1) ? hit_refs : hit_refs + REFS_W'(1);

  // Write-back decision for the item, taken once the scan is complete.
  always_comb begin
    tbl_we       = 1'b0;
    tbl_waddr    = hit_slot;
    tbl_wdata    = '0;
    peer_we      = 1'b0;
    peer_waddr   = hit_slot;
    res_status   = ST_NOT_FOUND;
    res_slot     = hit_slot;
    res_has_slot = 1'b0;
    res_count    = '0;
    case (op)
      OP_SUBSCRIBE: begin
        if (found) begin
          peer_we      = 1'b1;
          res_status   = ST_UPDATED;
          res_has_slot = 1'b1;
        end else if (free_found) begin
          tbl_we       = 1'b1;
          tbl_waddr    = free_slot;
          tbl_wdata    = {1'b1, key, {REFS_W{1'b0}}};
          peer_we      = 1'b1;
          peer_waddr   = free_slot;
          res_status   = ST_INSERTED;
          res_slot     = free_slot;
          res_has_slot = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_UNSUBSCRIBE: begin
        if (found) begin
          tbl_we       = 1'b1;
          tbl_wdata    = {1'b0, key, hit_refs};
          res_status   = ST_REMOVED;
          res_has_slot = 1'b1;
        end
      end
      OP_RECEIVE: begin
        if (found) begin
          tbl_we       = 1'b1;
          tbl_wdata    = {1'b1, key, refs_inc};
          res_status   = ST_COUNTED;
          res_has_slot = 1'b1;
          res_count    = refs_inc;
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
    // Commit only when the result register can take the result.
    if (state != S_WRITE || !out_free) begin
      tbl_we  = 1'b0;
      peer_we = 1'b0;
    end
    // The clearing pass owns the write port after reset.
    if (state == S_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = raddr;
      tbl_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (peer_we) begin
      peer_mem[peer_waddr] <= {addr, port};
    end
    rd_data <= tbl_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      // A result taken during the write-back is replaced by the new one there.
      if (out_valid && out_ready && state != S_WRITE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (cnt == CNT_W'(ENTRIES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op         <= opcode_t'(opcode);
            key        <= TOPIC_BITS'(topic_id);
            addr       <= peer_address;
            port       <= peer_port;
            cnt        <= '0;
            rd_pending <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue one read per cycle and compare the slot read in the previous cycle.
          if (cnt != CNT_W'(ENTRIES)) begin
            rd_slot    <= raddr;
            rd_pending <= 1'b1;
            cnt        <= cnt + CNT_W'(1);
          end else begin
            rd_pending <= 1'b0;
            state      <= S_WRITE;
          end
          if (rd_pending) begin
            if (rd_valid && rd_topic == key && !found) begin
              found    <= 1'b1;
              hit_slot <= rd_slot;
              hit_refs <= rd_refs;
            end
            if (!rd_valid && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_slot;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            slot_index <= res_has_slot ? SLOT_W'(res_slot) : '0;
            ref_count  <= res_count;
            cnt        <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TST_ASSERT_IMPLIES(a_result_from_commit, clk, rst, $rose(out_valid), $past(state == S_WRITE), "result appeared without a write-back")
  `TST_ASSERT_IMPLIES(a_no_write_in_scan, clk, rst, state == S_SCAN || state == S_IDLE, !tbl_we && !peer_we, "memory written outside write-back")
  `TST_ASSERT_IMPLIES(a_count_nonzero, clk, rst, out_valid && status == ST_COUNTED, ref_count != '0, "counted result with a zero count")
  `TST_ASSERT_IMPLIES(a_miss_fields_zero, clk, rst, out_valid && (status == ST_NOT_FOUND || status == ST_FULL), slot_index == '0 && ref_count == '0, "miss result carries slot or count")
  `TST_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(ref_count), "stalled result changed")

endmodule
